// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// implication in the same cycle, outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// implication in the following cycle, reset included
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ----- rtl/core/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// types, constants and the crc step for the stuffed frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int CSR_ADDR_W  = 2;
   localparam int RSP_FIELD_W = 58;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // transaction kinds on the request side
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_START_CODE      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ESCAPE_CODE     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ESCAPED_ESCAPE  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ESCAPED_START   = 2'd3;

   localparam logic [BYTE_W-1:0] START_CODE_RST     = 8'd115;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST    = 8'd120;
   localparam logic [BYTE_W-1:0] ESCAPED_ESCAPE_RST = 8'd85;
   localparam logic [BYTE_W-1:0] ESCAPED_START_RST  = 8'd49;

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

   // header layout, byte positions
   localparam logic [2:0] HDR_LEN_LO  = 3'd0;
   localparam logic [2:0] HDR_LEN_HI  = 3'd1;
   localparam logic [2:0] HDR_VERSION = 3'd2;
   localparam logic [2:0] HDR_SEQ_LO  = 3'd3;
   localparam logic [2:0] HDR_SEQ_HI  = 3'd4;
   localparam logic [2:0] HDR_COMMAND = 3'd5;
   localparam logic [2:0] HDR_CRC_LO  = 3'd6;
   localparam logic [2:0] HDR_CRC_HI  = 3'd7;

   localparam logic [WORD_W-1:0] HEADER_BYTES  = 16'd8;
   localparam logic [WORD_W-1:0] HEADER_LAST   = 16'd7;
   localparam logic [WORD_W-1:0] CRC_FIELD_POS = 16'd6;

   localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic                has_data;
      logic [BYTE_W-1:0]   payload_byte;
      logic                frame_end;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   version;
      logic [WORD_W-1:0]   sequence_res;
      logic [BYTE_W-1:0]   command;
      logic [WORD_W-1:0]   frame_length;
   } result_type;

   // one byte through crc-16, msb first, eight shift steps
   function automatic logic [WORD_W-1:0] crc16_step(input logic [WORD_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] r;
      r = crc ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (r[WORD_W-1]) begin
            r = {r[WORD_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[WORD_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stuffed_frame_receive_crc16.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_receive_crc16
// byte-stuffed frame receiver with header parse and crc-16 check
// ----------------------------------------------------------------------------
// One link byte or release command per request transaction, one per clock
// cycle while req_tready is high: each byte passes the unstuffing, header
// parse and an unrolled eight-bit crc-16 step in a single registered pass,
// and its result (if any) is registered into the output register, or into
// the skid register while the response side stalls. A payload byte gives a
// response with tuser set; the response that closes a frame has tlast set
// and carries status and header. The response side has a two-entry buffer
// (output register and skid register), so one stalled result does not stop
// the request side; a second waiting result drops req_tready. Configuration
// writes take effect at once and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module stuffed_frame_receive_crc16 (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sfr_pkg::BYTE_W-1:0]          req_tdata,  // rx_byte
   input  logic                                req_tuser,  // op
   // response side
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // payload_byte, status, version, sequence_res, command, frame_length, zero pad
   output logic [sfr_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,  // frame_end
   output logic                                rsp_tuser,  // has_data
   // configuration
   input  logic                                csr_we,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sfr_pkg::BYTE_W-1:0]          csr_wdata
);

   // configuration registers
   logic [sfr_pkg::BYTE_W-1:0] start_code_ff;
   logic [sfr_pkg::BYTE_W-1:0] escape_code_ff;
   logic [sfr_pkg::BYTE_W-1:0] escaped_escape_ff;
   logic [sfr_pkg::BYTE_W-1:0] escaped_start_ff;

   // receiver state
   logic                       escape_pending_ff, escape_pending_in;
   logic                       in_frame_ff, in_frame_in;
   logic                       frame_pending_ff, frame_pending_in;
   logic [sfr_pkg::WORD_W-1:0] byte_count_ff, byte_count_in;
   logic [sfr_pkg::WORD_W-1:0] length_word_ff, length_word_in;
   logic [sfr_pkg::BYTE_W-1:0] version_byte_ff, version_byte_in;
   logic [sfr_pkg::WORD_W-1:0] sequence_word_ff, sequence_word_in;
   logic [sfr_pkg::BYTE_W-1:0] command_byte_ff, command_byte_in;
   logic [sfr_pkg::WORD_W-1:0] crc_running_ff, crc_running_in;
   logic [sfr_pkg::WORD_W-1:0] crc_received_ff, crc_received_in;

   // response buffer
   sfr_pkg::result_type main_ff, main_in;
   sfr_pkg::result_type skid_ff, skid_in;
   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   logic                       accept;
   logic                       push;
   sfr_pkg::result_type        res;
   logic [sfr_pkg::BYTE_W-1:0] data_byte;
   logic [sfr_pkg::WORD_W-1:0] crc_next;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !skid_valid_ff;

   // unescape: the byte after an escape maps back to escape or start code
   always_comb begin
      data_byte = req_tdata;
      if (escape_pending_ff) begin
         if (req_tdata == escaped_escape_ff) begin
            data_byte = escape_code_ff;
         end else if (req_tdata == escaped_start_ff) begin
            data_byte = start_code_ff;
         end
      end
   end

   assign crc_next = sfr_pkg::crc16_step(crc_running_ff, data_byte);

   // per-transaction state update and result
   always_comb begin
      escape_pending_in = escape_pending_ff;
      in_frame_in       = in_frame_ff;
      frame_pending_in  = frame_pending_ff;
      byte_count_in     = byte_count_ff;
      length_word_in    = length_word_ff;
      version_byte_in   = version_byte_ff;
      sequence_word_in  = sequence_word_ff;
      command_byte_in   = command_byte_ff;
      crc_running_in    = crc_running_ff;
      crc_received_in   = crc_received_ff;
      res               = '0;
      push              = 1'b0;

      if (accept) begin
         if (req_tuser == sfr_pkg::OP_RELEASE) begin
            frame_pending_in = 1'b0;
         end else if (req_tdata == escape_code_ff) begin
            escape_pending_in = 1'b1;
         end else begin
            escape_pending_in = 1'b0;
            if (!escape_pending_ff && req_tdata == start_code_ff) begin
               // unescaped start: open a new frame unless one waits for release
               if (!frame_pending_ff) begin
                  in_frame_in      = 1'b1;
                  byte_count_in    = '0;
                  crc_running_in   = '0;
                  length_word_in   = '0;
                  version_byte_in  = '0;
                  sequence_word_in = '0;
                  command_byte_in  = '0;
                  crc_received_in  = '0;
               end
            end else if (in_frame_ff) begin
               byte_count_in = byte_count_ff + 16'd1;
               if (byte_count_ff < sfr_pkg::HEADER_BYTES) begin
                  // header byte
                  case (byte_count_ff[2:0])
                     sfr_pkg::HDR_LEN_LO:  length_word_in   = {length_word_ff[15:8], data_byte};
                     sfr_pkg::HDR_LEN_HI:  length_word_in   = {data_byte, length_word_ff[7:0]};
                     sfr_pkg::HDR_VERSION: version_byte_in  = data_byte;
                     sfr_pkg::HDR_SEQ_LO:  sequence_word_in = {sequence_word_ff[15:8], data_byte};
                     sfr_pkg::HDR_SEQ_HI:  sequence_word_in = {data_byte, sequence_word_ff[7:0]};
                     sfr_pkg::HDR_COMMAND: command_byte_in  = data_byte;
                     sfr_pkg::HDR_CRC_LO:  crc_received_in  = {crc_received_ff[15:8], data_byte};
                     default:              crc_received_in  = {data_byte, crc_received_ff[7:0]};
                  endcase
                  if (byte_count_ff < sfr_pkg::CRC_FIELD_POS) begin
                     crc_running_in = crc_next;
                  end
                  // header complete: short or header-only frames end here
                  if (byte_count_ff == sfr_pkg::HEADER_LAST) begin
                     if (length_word_ff < sfr_pkg::HEADER_BYTES) begin
                        push       = 1'b1;
                        res.status = sfr_pkg::STATUS_LEN_ERR;
                     end else if (length_word_ff == sfr_pkg::HEADER_BYTES) begin
                        push       = 1'b1;
                        res.status = (crc_running_ff == crc_received_in) ?
                                     sfr_pkg::STATUS_OK : sfr_pkg::STATUS_CRC_ERR;
                     end
                  end
               end else begin
                  // payload byte, passed out as it arrives
                  crc_running_in   = crc_next;
                  push             = 1'b1;
                  res.has_data     = 1'b1;
                  res.payload_byte = data_byte;
                  if (byte_count_in == length_word_ff) begin
                     res.status = (crc_next == crc_received_ff) ?
                                  sfr_pkg::STATUS_OK : sfr_pkg::STATUS_CRC_ERR;
                  end
               end

               // frame end: status already set, add header and close the frame
               if ((byte_count_ff == sfr_pkg::HEADER_LAST &&
                    length_word_ff <= sfr_pkg::HEADER_BYTES) ||
                   (byte_count_ff >= sfr_pkg::HEADER_BYTES &&
                    byte_count_in == length_word_ff)) begin
                  res.frame_end    = 1'b1;
                  res.version      = version_byte_ff;
                  res.sequence_res = sequence_word_ff;
                  res.command      = command_byte_ff;
                  res.frame_length = length_word_ff;
                  in_frame_in      = 1'b0;
                  frame_pending_in = 1'b1;
               end
            end
         end
      end
   end

   // two-entry response buffer: output register plus skid register
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // no new transaction is taken while the skid entry is full
         if (rsp_tready) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (main_valid_ff && !rsp_tready) begin
         if (push) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else begin
         main_in       = res;
         main_valid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff     <= sfr_pkg::START_CODE_RST;
         escape_code_ff    <= sfr_pkg::ESCAPE_CODE_RST;
         escaped_escape_ff <= sfr_pkg::ESCAPED_ESCAPE_RST;
         escaped_start_ff  <= sfr_pkg::ESCAPED_START_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            sfr_pkg::REG_START_CODE:     start_code_ff     <= csr_wdata;
            sfr_pkg::REG_ESCAPE_CODE:    escape_code_ff    <= csr_wdata;
            sfr_pkg::REG_ESCAPED_ESCAPE: escaped_escape_ff <= csr_wdata;
            sfr_pkg::REG_ESCAPED_START:  escaped_start_ff  <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
         in_frame_ff       <= 1'b0;
         frame_pending_ff  <= 1'b0;
         byte_count_ff     <= '0;
         length_word_ff    <= '0;
         version_byte_ff   <= '0;
         sequence_word_ff  <= '0;
         command_byte_ff   <= '0;
         crc_running_ff    <= '0;
         crc_received_ff   <= '0;
         main_valid_ff     <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         escape_pending_ff <= escape_pending_in;
         in_frame_ff       <= in_frame_in;
         frame_pending_ff  <= frame_pending_in;
         byte_count_ff     <= byte_count_in;
         length_word_ff    <= length_word_in;
         version_byte_ff   <= version_byte_in;
         sequence_word_ff  <= sequence_word_in;
         command_byte_ff   <= command_byte_in;
         crc_running_ff    <= crc_running_in;
         crc_received_ff   <= crc_received_in;
         main_valid_ff     <= main_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tuser  = main_ff.has_data;
   assign rsp_tlast  = main_ff.frame_end;
   assign rsp_tdata  = {{sfr_pkg::RSP_PAD_W{1'b0}},
                        main_ff.frame_length,
                        main_ff.command,
                        main_ff.sequence_res,
                        main_ff.version,
                        main_ff.status,
                        main_ff.payload_byte};

endmodule

`default_nettype wire

// ----- rtl/core/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// port-level checks for the stuffed frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [sfr_pkg::BYTE_W-1:0]      req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   logic unused_req;
   assign unused_req = req_tvalid ^ req_tready ^ req_tuser ^ (^req_tdata);

   // no response right after reset
   `ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)

   // a stalled response keeps its contents
   `ASSERT_NEXT(a_stall_hold, clock, !reset && rsp_tvalid && !rsp_tready, reset || (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))

   // every response carries data or closes a frame, a bare one has no payload
   `ASSERT_IMPLY(a_bare_is_end, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast && rsp_tdata[7:0] == 8'h00)

   // header and status fields are zero unless the frame ends
   `ASSERT_IMPLY(a_mid_zero, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[57:8] == 50'd0)

   // status never takes the unused code, pad bits stay zero
   `ASSERT_ALWAYS(a_status_code, clock, reset, !rsp_tvalid || (rsp_tdata[9:8] != 2'd3 && rsp_tdata[63:58] == 6'd0))

endmodule

bind stuffed_frame_receive_crc16 sfr_checker u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ----- tb/sfr_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_frame_checker
// watches both channels of the stuffed frame receiver, predicts every
// response from the accepted link bytes and compares it field by field
// ----------------------------------------------------------------------------
module sfr_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [sfr_pkg::BYTE_W-1:0]      req_tdata,  // rx_byte
   input  logic                            req_tuser,  // op
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // payload_byte, status, version, sequence_res, command, frame_length, zero pad
   input  logic [sfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,  // frame_end
   input  logic                            rsp_tuser,  // has_data
   input  logic                            csr_we,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [sfr_pkg::BYTE_W-1:0]      csr_wdata,
   output int                              mismatches,
   output int                              awaited
);
   import sfr_pkg::*;

   localparam int PRINT_CAP = 40;

   // response word, lowest field last
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [WORD_W-1:0]    frame_length;
      logic [BYTE_W-1:0]    command;
      logic [WORD_W-1:0]    sequence_res;
      logic [BYTE_W-1:0]    version;
      logic [STATUS_W-1:0]  status;
      logic [BYTE_W-1:0]    payload_byte;
   } rsp_word_type;

   // link codes as last written
   logic [BYTE_W-1:0] code_start, code_escape, code_esc_escape, code_esc_start;

   // receiver state
   bit                esc_seen, frame_open, frame_held;
   logic [WORD_W-1:0] rx_count, len_word, seq_word, crc_sum, crc_field;
   logic [BYTE_W-1:0] ver_byte, cmd_byte;

   result_type frame_results_q[$];

   initial begin
      mismatches = 0;
      awaited    = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_CAP) begin
         $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
      mismatches++;
   endtask

   function automatic logic [WORD_W-1:0] crc_xmodem_next(input logic [WORD_W-1:0] c,
                                                         input logic [BYTE_W-1:0] d);
      logic [WORD_W-1:0] acc;
      logic              fb;
      acc = c;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb  = acc[WORD_W-1] ^ d[i];
         acc = {acc[WORD_W-2:0], 1'b0};
         if (fb) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   task automatic close_frame(inout result_type r, input logic [STATUS_W-1:0] st);
      r.frame_end    = 1'b1;
      r.status       = st;
      r.version      = ver_byte;
      r.sequence_res = seq_word;
      r.command      = cmd_byte;
      r.frame_length = len_word;
      frame_open     = 1'b0;
      frame_held     = 1'b1;
   endtask

   function automatic logic [STATUS_W-1:0] crc_verdict();
      return (crc_sum == crc_field) ? STATUS_OK : STATUS_CRC_ERR;
   endfunction

   // one link byte or release through the receiver
   task automatic predict_link_byte(input logic op, input logic [BYTE_W-1:0] raw,
                                    output bit produced, output result_type r);
      logic [BYTE_W-1:0] b;
      bit                escaped;
      b        = raw;
      escaped  = 1'b0;
      produced = 1'b0;
      r        = '0;
      if (op == OP_RELEASE) begin
         frame_held = 1'b0;
      end else if (b == code_escape) begin
         esc_seen = 1'b1;
      end else begin
         if (esc_seen) begin
            if (b == code_esc_escape) begin
               b = code_escape;
            end else if (b == code_esc_start) begin
               b = code_start;
            end
            esc_seen = 1'b0;
            escaped  = 1'b1;
         end
         if (!escaped && b == code_start) begin
            // a held frame blocks new starts
            if (!frame_held) begin
               frame_open = 1'b1;
               rx_count   = '0;
               crc_sum    = '0;
               len_word   = '0;
               ver_byte   = '0;
               seq_word   = '0;
               cmd_byte   = '0;
               crc_field  = '0;
            end
         end else if (frame_open) begin
            if (rx_count < HEADER_BYTES) begin
               case (rx_count[2:0])
                  HDR_LEN_LO:  len_word[7:0]   = b;
                  HDR_LEN_HI:  len_word[15:8]  = b;
                  HDR_VERSION: ver_byte        = b;
                  HDR_SEQ_LO:  seq_word[7:0]   = b;
                  HDR_SEQ_HI:  seq_word[15:8]  = b;
                  HDR_COMMAND: cmd_byte        = b;
                  HDR_CRC_LO:  crc_field[7:0]  = b;
                  default:     crc_field[15:8] = b;
               endcase
               // the crc field itself is left out of the sum
               if (rx_count < CRC_FIELD_POS) begin
                  crc_sum = crc_xmodem_next(crc_sum, b);
               end
               rx_count = rx_count + 16'd1;
               if (rx_count == HEADER_BYTES) begin
                  if (len_word < HEADER_BYTES) begin
                     close_frame(r, STATUS_LEN_ERR);
                     produced = 1'b1;
                  end else if (len_word == HEADER_BYTES) begin
                     close_frame(r, crc_verdict());
                     produced = 1'b1;
                  end
               end
            end else begin
               crc_sum        = crc_xmodem_next(crc_sum, b);
               rx_count       = rx_count + 16'd1;
               produced       = 1'b1;
               r.has_data     = 1'b1;
               r.payload_byte = b;
               if (rx_count == len_word) begin
                  close_frame(r, crc_verdict());
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type word;
      result_type   want;
      result_type   next_result;
      bit           produced;
      if (reset) begin
         code_start      = START_CODE_RST;
         code_escape     = ESCAPE_CODE_RST;
         code_esc_escape = ESCAPED_ESCAPE_RST;
         code_esc_start  = ESCAPED_START_RST;
         esc_seen        = 1'b0;
         frame_open      = 1'b0;
         frame_held      = 1'b0;
         rx_count        = '0;
         len_word        = '0;
         seq_word        = '0;
         crc_sum         = '0;
         crc_field       = '0;
         ver_byte        = '0;
         cmd_byte        = '0;
         frame_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_START_CODE:     code_start      = csr_wdata;
               REG_ESCAPE_CODE:    code_escape     = csr_wdata;
               REG_ESCAPED_ESCAPE: code_esc_escape = csr_wdata;
               REG_ESCAPED_START:  code_esc_start  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            word = rsp_tdata;
            if (frame_results_q.size() == 0) begin
               report_mismatch("response with nothing expected", rsp_tdata, '0);
            end else begin
               want = frame_results_q.pop_front();
               if (rsp_tuser !== want.has_data)
                  report_mismatch("has_data", 64'(rsp_tuser), 64'(want.has_data));
               if (word.payload_byte !== want.payload_byte)
                  report_mismatch("payload_byte", 64'(word.payload_byte),
                                  64'(want.payload_byte));
               if (rsp_tlast !== want.frame_end)
                  report_mismatch("frame_end", 64'(rsp_tlast), 64'(want.frame_end));
               if (word.status !== want.status)
                  report_mismatch("status", 64'(word.status), 64'(want.status));
               if (word.version !== want.version)
                  report_mismatch("version", 64'(word.version), 64'(want.version));
               if (word.sequence_res !== want.sequence_res)
                  report_mismatch("sequence_res", 64'(word.sequence_res),
                                  64'(want.sequence_res));
               if (word.command !== want.command)
                  report_mismatch("command", 64'(word.command), 64'(want.command));
               if (word.frame_length !== want.frame_length)
                  report_mismatch("frame_length", 64'(word.frame_length),
                                  64'(want.frame_length));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_link_byte(req_tuser, req_tdata, produced, next_result);
            if (produced) begin
               frame_results_q.push_back(next_result);
            end
         end
      end
      awaited <= frame_results_q.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the stuffed frame receiver with crc-16 check
// ----------------------------------------------------------------------------
// Link bytes are built from whole frames (header, crc, payload) and stuffed
// with the current codes, mixed with short and bad-length frames, cut-off
// frames, starts while a frame is held, releases and loose noise bytes. The
// run walks through several sets of link codes, extremes included, with the
// block idle at every change. Both sides stall at random; the checker beside
// the block predicts and compares every response.
module testbench;
   import sfr_pkg::*;

   localparam int DRAIN_CYCLES   = 4;     // the block registers each result before it answers
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
   localparam int PHASE_ITEMS    = 115;

   typedef struct packed {
      logic              op;
      logic [BYTE_W-1:0] data;
   } link_item_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata;   // rx_byte
   logic                   req_tuser;   // op
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // payload_byte, status, version, sequence_res, command, frame_length, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;   // frame_end
   logic                   rsp_tuser;   // has_data
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [BYTE_W-1:0]      csr_wdata;

   int mismatches;
   int awaited;
   int idle_cycles = 0;

   // link codes the byte builder stuffs with
   logic [BYTE_W-1:0] link_start, link_escape, link_esc_escape, link_esc_start;
   bit                no_stall;
   link_item_type     link_q[$];

   stuffed_frame_receive_crc16 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   sfr_frame_checker frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_stall) return 0;
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // response side back-pressure
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = gap_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ends a hung run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_byte(input logic op, input logic [BYTE_W-1:0] b);
      link_q.push_back('{op: op, data: b});
   endtask

   // stuffs one frame byte; now and then an escape precedes a plain byte,
   // or a doubled escape, both of which leave the byte unchanged
   task automatic queue_stuffed(input logic [BYTE_W-1:0] b);
      if (b == link_escape || b == link_start ||
          (b != link_esc_escape && b != link_esc_start && $urandom_range(0, 15) == 0)) begin
         queue_byte(OP_BYTE, link_escape);
         if ($urandom_range(0, 7) == 0) begin
            queue_byte(OP_BYTE, link_escape);
         end
         if (b == link_escape) begin
            queue_byte(OP_BYTE, link_esc_escape);
         end else if (b == link_start) begin
            queue_byte(OP_BYTE, link_esc_start);
         end else begin
            queue_byte(OP_BYTE, b);
         end
      end else begin
         queue_byte(OP_BYTE, b);
      end
   endtask

   // start code, header with crc, then body bytes of payload
   task automatic queue_frame(input logic [WORD_W-1:0] len_field, input int body,
                              input bit good_crc, input bit code_payload);
      logic [BYTE_W-1:0] hdr [6];
      logic [BYTE_W-1:0] pay [$];
      logic [WORD_W-1:0] crc;
      logic [BYTE_W-1:0] b;
      hdr[0] = len_field[7:0];
      hdr[1] = len_field[15:8];
      hdr[2] = 8'($urandom_range(0, 255));
      hdr[3] = 8'($urandom_range(0, 255));
      hdr[4] = 8'($urandom_range(0, 255));
      hdr[5] = 8'($urandom_range(0, 255));
      crc = '0;
      foreach (hdr[i]) crc = sfr_pkg::crc16_step(crc, hdr[i]);
      for (int i = 0; i < body; i++) begin
         if (code_payload) begin
            b = i[0] ? link_escape : link_start;
         end else if ($urandom_range(0, 5) == 0) begin
            b = ($urandom_range(0, 1) != 0) ? link_escape : link_start;
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         pay.push_back(b);
         crc = sfr_pkg::crc16_step(crc, b);
      end
      if (!good_crc) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      queue_byte(OP_BYTE, link_start);
      foreach (hdr[i]) queue_stuffed(hdr[i]);
      queue_stuffed(crc[7:0]);
      queue_stuffed(crc[15:8]);
      foreach (pay[i]) queue_stuffed(pay[i]);
   endtask

   task automatic send_link_queue();
      link_item_type it;
      int            gap;
      while (link_q.size() > 0) begin
         it = link_q.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= it.op;
         req_tdata  <= it.data;
         do @(posedge clock); while (req_tready !== 1'b1);
         gap = gap_len();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // block idle: no request, every response in, pipeline flushed
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_codes(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                                input logic [BYTE_W-1:0] ee, input logic [BYTE_W-1:0] es);
      wait_idle();
      link_start      = s;
      link_escape     = e;
      link_esc_escape = ee;
      link_esc_start  = es;
      csr_we    <= 1'b1;
      csr_addr  <= REG_START_CODE;
      csr_wdata <= s;
      @(posedge clock);
      csr_addr  <= REG_ESCAPE_CODE;
      csr_wdata <= e;
      @(posedge clock);
      csr_addr  <= REG_ESCAPED_ESCAPE;
      csr_wdata <= ee;
      @(posedge clock);
      csr_addr  <= REG_ESCAPED_START;
      csr_wdata <= es;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // frames of random shape until the phase has moved enough frame bytes
   task automatic random_phase(input int budget);
      int                items;
      int                shape;
      int                payload;
      int                p;
      bit                complete;
      logic [WORD_W-1:0] len;
      items = 0;
      while (items < budget) begin
         shape    = $urandom_range(0, 99);
         complete = 1'b1;
         if (shape < 8) begin
            // length below the header size, trailing bytes fall outside
            queue_frame(16'($urandom_range(0, 7)), $urandom_range(0, 3),
                        $urandom_range(0, 1) != 0, 1'b0);
         end else if (shape < 14) begin
            queue_frame(HEADER_BYTES, 0, $urandom_range(0, 3) != 0, 1'b0);
         end else if (shape < 22) begin
            // cut off, the next start restarts the frame
            len = 16'($urandom_range(16, 16'hFFFF));
            queue_frame(len, $urandom_range(0, 6), 1'b1, 1'b0);
            complete = 1'b0;
         end else if (shape < 23) begin
            payload = $urandom_range(248, 300);
            queue_frame(16'(HEADER_BYTES + payload), payload, 1'b1, 1'b0);
         end else begin
            payload = $urandom_range(1, 12);
            queue_frame(16'(HEADER_BYTES + payload), payload,
                        $urandom_range(0, 4) != 0, 1'b0);
         end
         items += link_q.size();
         if (complete) begin
            p = $urandom_range(0, 99);
            if (p < 12) begin
               // start while the finished frame is still held
               queue_byte(OP_BYTE, link_start);
               repeat ($urandom_range(0, 3)) queue_byte(OP_BYTE, 8'($urandom_range(0, 255)));
               queue_byte(OP_RELEASE, 8'($urandom_range(0, 255)));
            end else if (p < 90) begin
               queue_byte(OP_RELEASE, 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) queue_byte(OP_BYTE, 8'($urandom_range(0, 255)));
         end
         send_link_queue();
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_BYTE;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_START_CODE;
      csr_wdata  <= '0;
      no_stall   = 1'b0;
      link_start      = START_CODE_RST;
      link_escape     = ESCAPE_CODE_RST;
      link_esc_escape = ESCAPED_ESCAPE_RST;
      link_esc_start  = ESCAPED_START_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: payload of escaped start and escape codes ending the frame,
      // a start while held, release, short length, bytes outside any frame
      queue_frame(HEADER_BYTES + 16'd2, 2, 1'b1, 1'b1);
      queue_byte(OP_BYTE, link_start);
      queue_byte(OP_RELEASE, 8'hFF);
      queue_frame(16'd3, 0, 1'b0, 1'b0);
      queue_byte(OP_RELEASE, 8'h00);
      queue_byte(OP_BYTE, 8'h00);
      queue_byte(OP_BYTE, 8'hFF);
      send_link_queue();

      random_phase(PHASE_ITEMS);

      // lowest and highest codes
      program_codes(8'h00, 8'hFF, 8'hFE, 8'h01);
      random_phase(PHASE_ITEMS);

      // both escaped codes the same, start code stands for escape
      program_codes(8'hFF, 8'h00, 8'h7E, 8'h7E);
      random_phase(PHASE_ITEMS);

      // a stretch with no idling on either side
      program_codes(8'h7E, 8'h7D, 8'h5D, 8'h5E);
      no_stall = 1'b1;
      random_phase(PHASE_ITEMS);
      no_stall = 1'b0;

      begin
         logic [BYTE_W-1:0] s;
         s = 8'($urandom_range(0, 255));
         program_codes(s, s ^ 8'($urandom_range(1, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      random_phase(PHASE_ITEMS);

      program_codes(START_CODE_RST, ESCAPE_CODE_RST, ESCAPED_ESCAPE_RST, ESCAPED_START_RST);
      random_phase(PHASE_ITEMS);

      wait_idle();
      if (mismatches == 0 && awaited == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
